/* rtl/obm_pkg.sv */
// Shared types and constants for the overlapping box merger.
package obm_pkg;

	// Field widths of words and configuration registers.
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned EDGE_W     = 13;
	localparam int unsigned SLOT_W     = 5;
	localparam int unsigned TOTAL_W    = 6;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 12;

	// Default table depth.
	localparam int unsigned OBM_MAX_BOXES = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_W-1:0] WINDOW_WIDTH_RST  = 12'd55;
	localparam logic [CFG_DATA_W-1:0] WINDOW_HEIGHT_RST = 12'd110;

	// One stored box as held in the table memory.
	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [EDGE_W-1:0]  right;
		logic [EDGE_W-1:0]  bottom;
	} box_t;

	// Port strobes from the controller to the table memory.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

/* rtl/obm_if.sv */
// Handshake channel interfaces for detection corners and merge results.
interface obm_corner_if;
	logic                       valid;
	logic                       ready;
	logic [obm_pkg::COORD_W-1:0] corner_x;
	logic [obm_pkg::COORD_W-1:0] corner_y;

	modport source (output valid, output corner_x, output corner_y, input ready);
	modport sink   (input valid, input corner_x, input corner_y, output ready);
endinterface

interface obm_result_if;
	logic                        valid;
	logic                        ready;
	logic [obm_pkg::SLOT_W-1:0]  slot;
	logic                        merged;
	logic                        dropped;
	logic [obm_pkg::COORD_W-1:0] box_left;
	logic [obm_pkg::COORD_W-1:0] box_top;
	logic [obm_pkg::EDGE_W-1:0]  box_right;
	logic [obm_pkg::EDGE_W-1:0]  box_bottom;
	logic [obm_pkg::TOTAL_W-1:0] box_total;

	modport source (output valid, output slot, output merged, output dropped,
		output box_left, output box_top, output box_right, output box_bottom,
		output box_total, input ready);
	modport sink   (input valid, input slot, input merged, input dropped,
		input box_left, input box_top, input box_right, input box_bottom,
		input box_total, output ready);
endinterface

/* rtl/obm_box_mem.sv */
// Box table memory: one write port and one registered read port.
module obm_box_mem #(
	parameter int unsigned MAX_BOXES = obm_pkg::OBM_MAX_BOXES,
	parameter int unsigned IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                clk,
	input  obm_pkg::mem_ctl_t   ctl,
	input  logic [IDX_W-1:0]    raddr,
	input  logic [IDX_W-1:0]    waddr,
	input  obm_pkg::box_t       wdata,
	output obm_pkg::box_t       rdata
);
	import obm_pkg::*;

	box_t mem_q [MAX_BOXES];
	box_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/obm_ctrl.sv */
// Scan and merge controller: walks the table, merges or appends, drives results.
module obm_ctrl #(
	parameter int unsigned MAX_BOXES = obm_pkg::OBM_MAX_BOXES,
	parameter int unsigned IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [obm_pkg::CFG_DATA_W-1:0]   window_width,
	input  logic [obm_pkg::CFG_DATA_W-1:0]   window_height,
	obm_corner_if.sink                       det,
	obm_result_if.source                     res,
	output obm_pkg::mem_ctl_t                mem_ctl,
	output logic [IDX_W-1:0]                 mem_raddr,
	output logic [IDX_W-1:0]                 mem_waddr,
	output obm_pkg::box_t                    mem_wdata,
	input  obm_pkg::box_t                    mem_rdata
);
	import obm_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             issue_done_q;
	logic             chk_valid_s1;
	logic [CNT_W-1:0] chk_idx_s1;
	box_t             win_q;
	box_t             res_box_q;
	logic [CNT_W-1:0] slot_q;
	logic             merged_q;
	logic             dropped_q;

	logic             out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_merged_q;
	logic               out_dropped_q;
	box_t               out_box_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic             accept;
	logic             rd_en;
	logic             overlap;
	logic             hit;
	logic             last_chk;
	logic             out_load;
	logic [CNT_W-1:0] last_idx;
	box_t             win_new;
	box_t             union_box;

	// Handshake and memory strobes.
	always_comb begin
		det.ready       = (state_q == ST_IDLE);
		accept          = det.valid && (state_q == ST_IDLE);
		rd_en           = (state_q == ST_SCAN) && !issue_done_q;
		mem_ctl.rd_en   = rd_en;
		mem_ctl.wr_en   = (state_q == ST_WRITE);
		mem_raddr       = rd_idx_q[IDX_W-1:0];
		mem_waddr       = slot_q[IDX_W-1:0];
		mem_wdata       = res_box_q;
		last_idx        = count_q - CNT_W'(1);
		out_load        = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	end

	// Window box formed from the incoming corner.
	always_comb begin
		win_new.left   = det.corner_x;
		win_new.top    = det.corner_y;
		win_new.right  = EDGE_W'(det.corner_x) + EDGE_W'(window_width);
		win_new.bottom = EDGE_W'(det.corner_y) + EDGE_W'(window_height);
	end

	// Overlap test against the entry just read; touching edges overlap.
	always_comb begin
		overlap = !(EDGE_W'(win_q.left) > mem_rdata.right)
			&& !(EDGE_W'(mem_rdata.left) > win_q.right)
			&& !(win_q.bottom < EDGE_W'(mem_rdata.top))
			&& !(mem_rdata.bottom < EDGE_W'(win_q.top));
		hit      = (state_q == ST_SCAN) && chk_valid_s1 && overlap;
		last_chk = (state_q == ST_SCAN) && chk_valid_s1 && (chk_idx_s1 == last_idx);
	end

	// Union of the window and the stored box.
	always_comb begin
		union_box.left   = (win_q.left < mem_rdata.left) ? win_q.left : mem_rdata.left;
		union_box.top    = (win_q.top < mem_rdata.top) ? win_q.top : mem_rdata.top;
		union_box.right  = (win_q.right > mem_rdata.right) ? win_q.right : mem_rdata.right;
		union_box.bottom = (win_q.bottom > mem_rdata.bottom) ? win_q.bottom
			: mem_rdata.bottom;
	end

	// Sequencer: accept, scan, write back, hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			issue_done_q <= 1'b0;
			chk_valid_s1 <= 1'b0;
		end else begin
			chk_valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_done_q <= 1'b0;
						state_q      <= (count_q == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en && (rd_idx_q == last_idx)) begin
						issue_done_q <= 1'b1;
					end
					if (hit) begin
						state_q <= ST_WRITE;
					end else if (last_chk) begin
						state_q <= (count_q == CNT_MAX) ? ST_DONE : ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (!merged_q) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		chk_idx_s1 <= rd_idx_q;
		if (accept) begin
			win_q     <= win_new;
			rd_idx_q  <= '0;
			slot_q    <= count_q;
			res_box_q <= win_new;
			merged_q  <= 1'b0;
			dropped_q <= 1'b0;
		end else if (hit) begin
			slot_q    <= chk_idx_s1;
			res_box_q <= union_box;
			merged_q  <= 1'b1;
		end else if (last_chk) begin
			if (count_q == CNT_MAX) begin
				slot_q    <= '0;
				res_box_q <= '0;
				dropped_q <= 1'b1;
			end else begin
				slot_q    <= count_q;
				res_box_q <= win_q;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q    <= SLOT_W'(slot_q);
			out_merged_q  <= merged_q;
			out_dropped_q <= dropped_q;
			out_box_q     <= res_box_q;
			out_total_q   <= TOTAL_W'(count_q);
		end
	end

	always_comb begin
		res.valid      = out_valid_q;
		res.slot       = out_slot_q;
		res.merged     = out_merged_q;
		res.dropped    = out_dropped_q;
		res.box_left   = out_box_q.left;
		res.box_top    = out_box_q.top;
		res.box_right  = out_box_q.right;
		res.box_bottom = out_box_q.bottom;
		res.box_total  = out_total_q;
	end

endmodule

/* rtl/overlapping_box_merger.sv */
// Top level of the overlapping box merger: configuration registers and table.
//
// A detection word on det carries the top-left corner of a window; the window
// extends by the configured width and height. The block scans its box table
// from entry 0, grows the first box that overlaps or touches the window to
// their union, or appends the window when nothing overlaps. With a full table
// and no overlap the window is dropped and flagged. Exactly one result word
// leaves on res for each detection word.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 is
// the window width, index 1 the window height. Write only while idle.
// The scan reads one table entry per cycle from the box memory; an empty table
// skips the scan, and a merge into an entry ends it early. One detection is in
// work at a time and the next can be accepted the cycle after its result is
// loaded; det.ready is high only while idle. Reset clears the box count and
// loads the default window size (55 by 110); the table contents need no
// clearing. A result that res does not take waits in the output register; the
// next detection is still accepted and its result is held inside until the
// output register frees up.
module overlapping_box_merger #(
	parameter int unsigned MAX_BOXES = obm_pkg::OBM_MAX_BOXES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [obm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [obm_pkg::CFG_DATA_W-1:0]   cfg_data,
	obm_corner_if.sink                       det,
	obm_result_if.source                     res
);
	import obm_pkg::*;

	localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	logic [CFG_DATA_W-1:0] window_width_q;
	logic [CFG_DATA_W-1:0] window_height_q;
	mem_ctl_t              mem_ctl;
	logic [IDX_W-1:0]      mem_raddr;
	logic [IDX_W-1:0]      mem_waddr;
	box_t                  mem_wdata;
	box_t                  mem_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= WINDOW_WIDTH_RST;
			window_height_q <= WINDOW_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_WIDTH:  window_width_q  <= cfg_data;
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	obm_ctrl #(
		.MAX_BOXES (MAX_BOXES),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_width  (window_width_q),
		.window_height (window_height_q),
		.det           (det),
		.res           (res),
		.mem_ctl       (mem_ctl),
		.mem_raddr     (mem_raddr),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata)
	);

	obm_box_mem #(
		.MAX_BOXES (MAX_BOXES),
		.IDX_W     (IDX_W)
	) u_box_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.raddr (mem_raddr),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

/* test/overlapping_box_merger_tb.sv */
// Self-checking testbench for the overlapping box merger: directed table, then random phases.
module overlapping_box_merger_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obm_pkg::*;

	localparam int unsigned TABLE_DEPTH = OBM_MAX_BOXES;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned NUM_PHASES  = 7;

	// One result word as the block reports it.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               merged;
		logic               dropped;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [EDGE_W-1:0]  right;
		logic [EDGE_W-1:0]  bottom;
		logic [TOTAL_W-1:0] total;
	} merge_word_t;

	// Rows of the directed table.
	typedef enum logic [1:0] {ROW_CORNER, ROW_KNOWN, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic [COORD_W-1:0]    cx;
		logic [COORD_W-1:0]    cy;
		merge_word_t           known;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	obm_corner_if det_if ();
	obm_result_if res_if ();

	overlapping_box_merger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.det       (det_if),
		.res       (res_if)
	);

	// Shadow copy of the block's registers and box table.
	logic [CFG_DATA_W-1:0] win_w;
	logic [CFG_DATA_W-1:0] win_h;
	logic [COORD_W-1:0]    tbl_left   [TABLE_DEPTH];
	logic [COORD_W-1:0]    tbl_top    [TABLE_DEPTH];
	logic [EDGE_W-1:0]     tbl_right  [TABLE_DEPTH];
	logic [EDGE_W-1:0]     tbl_bottom [TABLE_DEPTH];
	int                    box_count;

	merge_word_t pending_merges[$];
	row_t        directed_rows[$];
	int          mismatch_count;
	bit          calm;

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one detection window to the shadow table and return the expected word.
	function automatic merge_word_t merge_window(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy);
		logic [EDGE_W-1:0] r;
		logic [EDGE_W-1:0] b;
		merge_word_t w;
		int hit;
		int i;
		r = {1'b0, cx} + {1'b0, win_w};
		b = {1'b0, cy} + {1'b0, win_h};
		hit = -1;
		w = '0;
		// The first stored box that is not strictly apart on either axis wins.
		for (i = 0; i < box_count; i++) begin
			if (hit < 0 && !({1'b0, cx} > tbl_right[i] || {1'b0, tbl_left[i]} > r ||
					b < {1'b0, tbl_top[i]} || tbl_bottom[i] < {1'b0, cy})) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			if (cx < tbl_left[hit]) tbl_left[hit] = cx;
			if (cy < tbl_top[hit]) tbl_top[hit] = cy;
			if (r > tbl_right[hit]) tbl_right[hit] = r;
			if (b > tbl_bottom[hit]) tbl_bottom[hit] = b;
			w.slot   = hit[SLOT_W-1:0];
			w.merged = 1'b1;
			w.left   = tbl_left[hit];
			w.top    = tbl_top[hit];
			w.right  = tbl_right[hit];
			w.bottom = tbl_bottom[hit];
		end else if (box_count >= TABLE_DEPTH) begin
			// Full table and nothing overlaps: the window is discarded.
			w.dropped = 1'b1;
		end else begin
			tbl_left[box_count]   = cx;
			tbl_top[box_count]    = cy;
			tbl_right[box_count]  = r;
			tbl_bottom[box_count] = b;
			w.slot   = box_count[SLOT_W-1:0];
			w.left   = cx;
			w.top    = cy;
			w.right  = r;
			w.bottom = b;
			box_count++;
		end
		w.total = box_count[TOTAL_W-1:0];
		return w;
	endfunction

	// Compare one field of a result word.
	function automatic void check_field(input string name, input logic [EDGE_W-1:0] want,
			input logic [EDGE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Table rows; a known word is typed in only where it is obvious.
	task automatic add_row(input row_kind_t kind, input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input merge_word_t known);
		row_t row;
		row.kind      = kind;
		row.reg_index = REG_WINDOW_WIDTH;
		row.reg_value = '0;
		row.cx        = cx;
		row.cy        = cy;
		row.known     = known;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic add_reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		row_t row;
		row.kind      = ROW_REG;
		row.reg_index = idx;
		row.reg_value = value;
		row.cx        = '0;
		row.cy        = '0;
		row.known     = '0;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// Offer one corner word, with a random gap before it outside calm stretches, and record the expected merge.
	task automatic send_corner(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input bit use_known, input merge_word_t known);
		int gap;
		merge_word_t w;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < 13) gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			det_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		det_if.valid    <= 1'b1;
		det_if.corner_x <= cx;
		det_if.corner_y <= cy;
		@(posedge clk);
		while (det_if.ready !== 1'b1) @(posedge clk);
		w = merge_window(cx, cy);
		pending_merges.insert(pending_merges.size(), use_known ? known : w);
	endtask

	// Hold off the sender until every expected word has come back.
	task automatic drain();
		@(negedge clk);
		det_if.valid <= 1'b0;
		while (pending_merges.size() != 0) @(negedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW_WIDTH) begin
			win_w = value;
		end else begin
			win_h = value;
		end
	endtask

	// Result sink: random back-pressure except in calm stretches.
	always @(negedge clk) begin
		res_if.ready <= calm || ($urandom_range(99) >= 13);
	end

	// Result checker: each accepted word against the oldest expectation.
	always @(posedge clk) begin
		merge_word_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (pending_merges.size() == 0) begin
				$error("result word with no detection pending");
				mismatch_count++;
			end else begin
				want = pending_merges.pop_front();
				check_field("slot", EDGE_W'(want.slot), EDGE_W'(res_if.slot));
				check_field("merged", EDGE_W'(want.merged), EDGE_W'(res_if.merged));
				check_field("dropped", EDGE_W'(want.dropped), EDGE_W'(res_if.dropped));
				check_field("box_left", EDGE_W'(want.left), EDGE_W'(res_if.box_left));
				check_field("box_top", EDGE_W'(want.top), EDGE_W'(res_if.box_top));
				check_field("box_right", want.right, res_if.box_right);
				check_field("box_bottom", want.bottom, res_if.box_bottom);
				check_field("box_total", EDGE_W'(want.total), EDGE_W'(res_if.box_total));
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((det_if.valid === 1'b1 && det_if.ready === 1'b1) ||
					(res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("overlapping_box_merger_tb: done, errors");
		$finish;
	end

	// Main stimulus.
	initial begin : stimulus
		int phase_items [NUM_PHASES];
		logic [CFG_DATA_W-1:0] new_w;
		logic [CFG_DATA_W-1:0] new_h;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		int pick;
		int lo;
		int hi;
		int p;
		int n;
		int r;

		phase_items     = '{500, 200, 300, 150, 150, 200, 150};
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_WINDOW_WIDTH;
		cfg_data        = '0;
		det_if.valid    = 1'b0;
		det_if.corner_x = '0;
		det_if.corner_y = '0;
		calm            = 1'b0;
		mismatch_count  = 0;
		win_w           = WINDOW_WIDTH_RST;
		win_h           = WINDOW_HEIGHT_RST;
		box_count       = 0;

		// Directed table, starting from the reset size of 55 by 110.
		add_row(ROW_KNOWN, 12'd100, 12'd200, '{5'd0, 1'b0, 1'b0, 12'd100, 12'd200,
			13'd155, 13'd310, 6'd1});
		add_row(ROW_KNOWN, 12'd0, 12'd0, '{5'd1, 1'b0, 1'b0, 12'd0, 12'd0,
			13'd55, 13'd110, 6'd2});
		add_row(ROW_KNOWN, 12'd4095, 12'd4095, '{5'd2, 1'b0, 1'b0, 12'd4095, 12'd4095,
			13'd4150, 13'd4205, 6'd3});
		// Corner-to-corner touch counts as overlap.
		add_row(ROW_KNOWN, 12'd155, 12'd310, '{5'd0, 1'b1, 1'b0, 12'd100, 12'd200,
			13'd210, 13'd420, 6'd3});
		add_row(ROW_KNOWN, 12'd45, 12'd0, '{5'd1, 1'b1, 1'b0, 12'd0, 12'd0,
			13'd100, 13'd110, 6'd3});
		// One pixel to the right of a box is strictly apart.
		add_row(ROW_KNOWN, 12'd101, 12'd0, '{5'd3, 1'b0, 1'b0, 12'd101, 12'd0,
			13'd156, 13'd110, 6'd4});
		add_row(ROW_KNOWN, 12'd4040, 12'd3985, '{5'd2, 1'b1, 1'b0, 12'd4040, 12'd3985,
			13'd4150, 13'd4205, 6'd4});
		add_row(ROW_CORNER, 12'd2048, 12'd1024, '0);
		add_row(ROW_CORNER, 12'd1024, 12'd2048, '0);
		add_row(ROW_CORNER, 12'd4095, 12'd0, '0);
		add_row(ROW_CORNER, 12'd0, 12'd4095, '0);
		add_row(ROW_CORNER, 12'd2730, 12'd1365, '0);
		// Zero extent on both axes.
		add_reg_row(REG_WINDOW_WIDTH, 12'd0);
		add_reg_row(REG_WINDOW_HEIGHT, 12'd0);
		add_row(ROW_CORNER, 12'd3000, 12'd3000, '0);
		add_row(ROW_CORNER, 12'd3000, 12'd3000, '0);
		add_row(ROW_CORNER, 12'd3000, 12'd3001, '0);
		// Largest extent gives the largest edge sums.
		add_reg_row(REG_WINDOW_WIDTH, 12'd4095);
		add_reg_row(REG_WINDOW_HEIGHT, 12'd4095);
		add_row(ROW_CORNER, 12'd4095, 12'd4095, '0);
		add_reg_row(REG_WINDOW_WIDTH, 12'd1);
		add_row(ROW_CORNER, 12'd0, 12'd2000, '0);

		// Single reset at the start of the run.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_REG) begin
				write_reg(directed_rows[k].reg_index, directed_rows[k].reg_value);
			end else begin
				send_corner(directed_rows[k].cx, directed_rows[k].cy,
					directed_rows[k].kind == ROW_KNOWN, directed_rows[k].known);
			end
		end

		// Random phases, each under its own window size.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					new_w = CFG_DATA_W'($urandom_range(8, 1));
					new_h = CFG_DATA_W'($urandom_range(8, 1));
				end
				1: begin
					new_w = '0;
					new_h = '0;
				end
				2: begin
					new_w = CFG_DATA_W'($urandom_range(400, 1));
					new_h = CFG_DATA_W'($urandom_range(400, 1));
				end
				3: begin
					new_w = 12'd4095;
					new_h = 12'd1;
				end
				4: begin
					new_w = 12'd1;
					new_h = 12'd4095;
				end
				5: begin
					new_w = CFG_DATA_W'($urandom_range(4095, 0));
					new_h = CFG_DATA_W'($urandom_range(4095, 0));
				end
				default: begin
					new_w = WINDOW_WIDTH_RST;
					new_h = WINDOW_HEIGHT_RST;
				end
			endcase
			write_reg(REG_WINDOW_WIDTH, new_w);
			write_reg(REG_WINDOW_HEIGHT, new_h);
			// One long stretch with no idling on either side.
			calm = (p == 2);
			for (n = 0; n < phase_items[p]; n++) begin
				if (p == 0 && n == 250) drain();
				cx = COORD_W'($urandom_range(4095, 0));
				cy = COORD_W'($urandom_range(4095, 0));
				// Aim part of the words at a stored box, often right on its edge.
				if (box_count > 0 && $urandom_range(99) < 40) begin
					pick = $urandom_range(box_count - 1, 0);
					lo = (tbl_left[pick] > win_w) ? int'(tbl_left[pick]) - int'(win_w) : 0;
					hi = (tbl_right[pick] < 4095) ? int'(tbl_right[pick]) : 4095;
					r = $urandom_range(3, 0);
					cx = (r == 0) ? lo[COORD_W-1:0] : (r == 1) ? hi[COORD_W-1:0] :
						COORD_W'($urandom_range(hi, lo));
					lo = (tbl_top[pick] > win_h) ? int'(tbl_top[pick]) - int'(win_h) : 0;
					hi = (tbl_bottom[pick] < 4095) ? int'(tbl_bottom[pick]) : 4095;
					r = $urandom_range(3, 0);
					cy = (r == 0) ? lo[COORD_W-1:0] : (r == 1) ? hi[COORD_W-1:0] :
						COORD_W'($urandom_range(hi, lo));
				end
				send_corner(cx, cy, 1'b0, '0);
			end
		end
		calm = 1'b0;

		// Let the last words come back, then settle.
		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_merges.size() == 0) begin
			$display("overlapping_box_merger_tb: done, clean");
		end else begin
			$display("overlapping_box_merger_tb: done, errors");
		end
		$finish;
	end

endmodule
